>>> rtl/teq_pkg.sv
package teq_pkg;

   localparam int QUEUE_DEPTH_DEF = 64;

   localparam int OP_W      = 3;
   localparam int DELAY_W   = 32;
   localparam int HANDLER_W = 8;
   localparam int UID_W     = 31;
   localparam int TIME_W    = 48;
   localparam int STATUS_W  = 3;
   localparam int OCC_W     = 7;
   localparam int ID_W      = 32;

   localparam int REQ_W  = 80;
   localparam int RSP_W  = 152;

   localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE  = 3'd1;
   localparam logic [OP_W-1:0] OP_CANCEL   = 3'd2;
   localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd3;
   localparam logic [OP_W-1:0] OP_RESET    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NEG_DELAY = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NULL_HDL  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_IDS    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd6;
   localparam logic [STATUS_W-1:0] ST_BACKWARDS = 3'd7;

   typedef struct packed {
      logic [TIME_W-1:0]    due_time;
      logic [UID_W-1:0]     uid;
      logic [HANDLER_W-1:0] handler;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   // Broadcast from the controller to every cell of the row.
   typedef struct packed {
      logic              cmp;
      logic              dequeue;
      logic              find;
      logic [UID_W-1:0]  uid;
      logic [TIME_W-1:0] due_time;
      logic              ins_en;
      logic              rem_en;
      slot_type          new_slot;
   } cell_ctl_type;

endpackage

>>> rtl/teq_cell.sv
module teq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  teq_pkg::cell_ctl_type ctl,
   input  logic                  live,
   input  logic                  head,
   input  logic                  prev_ins,
   input  logic                  rem,
   input  teq_pkg::slot_type     prev_slot,
   input  teq_pkg::slot_type     next_slot,
   output teq_pkg::slot_type     slot,
   output logic                  ins,
   output logic                  match
);
   import teq_pkg::*;

   slot_type slot_ff, slot_in;
   logic     ins_ff, ins_in;
   logic     match_ff, match_in;

   always_comb begin
      ins_in   = ins_ff;
      match_in = match_ff;
      slot_in  = slot_ff;
      if (ctl.cmp) begin
         // Free cells count as later than any due time, so the insert point
         // is the first cell whose flag is set.
         ins_in   = !live || (slot_ff.due_time > ctl.due_time);
         match_in = live && ((ctl.dequeue && head) ||
                    (ctl.find && (ctl.uid != '0) && (slot_ff.uid == ctl.uid)));
      end
      if (ctl.ins_en && ins_ff) begin
         slot_in = prev_ins ? prev_slot : ctl.new_slot;
      end else if (ctl.rem_en && rem) begin
         slot_in = next_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ins_ff   <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         ins_ff   <= ins_in;
         match_ff <= match_in;
      end
      slot_ff <= slot_in;
   end

   assign slot  = slot_ff;
   assign ins   = ins_ff;
   assign match = match_ff;

endmodule

>>> rtl/time_ordered_event_queue_top.sv
// Time-ordered event queue: a row of QUEUE_DEPTH cells holds the waiting
// events sorted by due time, arrival order kept among equal times. Each
// request word passes a compare state and then an update state: in the
// first every cell compares its entry with the new due time or the requested
// id, in the second the row shifts by one place toward the tail (schedule)
// or toward the head (dequeue, cancel) and the response word is loaded into
// the output register once it is free. A new request is taken in the update
// cycle, so back-to-back requests overlap as long as responses are taken.
// Opcodes 5 to 7 are consumed without a response. The start_time register
// is applied at reset of the clock (opcode 4); reset zeroes it and the
// clock. Writes are taken at any time while no request is in flight.
module time_ordered_event_queue_top #(
   parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // opcode[2:0], delay[34:3], handler_id[42:35], event_uid[73:43], zero fill
   input  logic [teq_pkg::REQ_W-1:0]   req_tdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // status[2:0], result_uid[33:3], result_time[81:34], result_handler[89:82],
   // current_time[137:90], occupancy[144:138], zero fill
   output logic [teq_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [teq_pkg::TIME_W-1:0]  csr_data,
   input  logic                        csr_valid,
   output logic                        csr_ready
);
   import teq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_CMP, S_APPLY} state_type;

   state_type             state_ff;
   logic [OP_W-1:0]       op_ff;
   logic [DELAY_W-1:0]    delay_ff;
   logic [HANDLER_W-1:0]  handler_ff;
   logic [UID_W-1:0]      uid_ff;
   logic [TIME_W-1:0]     due_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [TIME_W-1:0]     clock_ff, clock_in;
   logic [ID_W-1:0]       next_id_ff, next_id_in;
   logic [TIME_W-1:0]     start_ff;
   logic                  rsp_valid_ff;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   logic                  out_free, apply_fire, req_fire, op_valid;
   logic                  full, sched_ok, found;
   logic [TIME_W+1:0]     sum;
   logic [TIME_W-1:0]     due_in;
   logic [STATUS_W-1:0]   status;
   slot_type              new_slot, hit, res_slot;
   cell_ctl_type          ctl;

   slot_type              slot_vec [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] ins_vec, match_vec, rem_vec, live_vec;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign apply_fire = (state_ff == S_APPLY) && out_free;
   assign req_tready = (state_ff == S_IDLE) || apply_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign op_valid   = (req_tdata[2:0] == OP_SCHEDULE) || (req_tdata[2:0] == OP_DEQUEUE) ||
                       (req_tdata[2:0] == OP_CANCEL) || (req_tdata[2:0] == OP_LOOKUP) ||
                       (req_tdata[2:0] == OP_RESET);
   assign csr_ready  = 1'b1;

   // Due time: clock plus signed delay, clamped to the 48-bit range.
   assign sum = {2'b00, clock_ff} + {{(TIME_W + 2 - DELAY_W){delay_ff[DELAY_W-1]}}, delay_ff};
   always_comb begin
      if (sum[TIME_W+1]) begin
         due_in = '0;
      end else if (sum[TIME_W]) begin
         due_in = '1;
      end else begin
         due_in = sum[TIME_W-1:0];
      end
   end

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign sched_ok = (handler_ff != '0) && !full && !next_id_ff[ID_W-1];
   assign found    = |match_vec;

   assign new_slot.due_time = due_ff;
   assign new_slot.uid      = next_id_ff[UID_W-1:0];
   assign new_slot.handler  = handler_ff;

   always_comb begin
      ctl          = '0;
      ctl.cmp      = (state_ff == S_CMP);
      ctl.dequeue  = (op_ff == OP_DEQUEUE);
      ctl.find     = (op_ff == OP_CANCEL) || (op_ff == OP_LOOKUP);
      ctl.uid      = uid_ff;
      ctl.due_time = due_in;
      ctl.ins_en   = apply_fire && (op_ff == OP_SCHEDULE) && sched_ok;
      ctl.rem_en   = apply_fire && (((op_ff == OP_DEQUEUE) && (count_ff != '0)) ||
                     ((op_ff == OP_CANCEL) && found));
      ctl.new_slot = new_slot;
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      slot_type prev_slot, next_slot;
      logic     prev_ins;

      if (i == 0) begin : g_first
         assign prev_slot = '0;
         assign prev_ins  = 1'b0;
      end else begin : g_mid
         assign prev_slot = slot_vec[i-1];
         assign prev_ins  = ins_vec[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_slot = '0;
      end else begin : g_inner
         assign next_slot = slot_vec[i+1];
      end

      assign live_vec[i] = (CNT_W'(i) < count_ff);
      // Every cell at or behind the removed entry pulls from its successor.
      assign rem_vec[i]  = |match_vec[i:0];

      teq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .live      (live_vec[i]),
         .head      (i == 0),
         .prev_ins  (prev_ins),
         .rem       (rem_vec[i]),
         .prev_slot (prev_slot),
         .next_slot (next_slot),
         .slot      (slot_vec[i]),
         .ins       (ins_vec[i]),
         .match     (match_vec[i])
      );
   end

   // Uids are unique, so at most one cell flags a match.
   always_comb begin
      hit = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         hit = hit | (slot_vec[i] & {SLOT_W{match_vec[i]}});
      end
   end

   always_comb begin
      status     = ST_OK;
      res_slot   = '0;
      count_in   = count_ff;
      clock_in   = clock_ff;
      next_id_in = next_id_ff;
      unique case (op_ff)
         OP_SCHEDULE: begin
            if (handler_ff == '0) begin
               status = ST_NULL_HDL;
            end else if (full) begin
               status = ST_FULL;
            end else if (next_id_ff[ID_W-1]) begin
               status = ST_NO_IDS;
            end else begin
               status     = delay_ff[DELAY_W-1] ? ST_NEG_DELAY : ST_OK;
               res_slot   = new_slot;
               count_in   = count_ff + 1'b1;
               next_id_in = next_id_ff + 1'b1;
            end
         end
         OP_DEQUEUE: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               res_slot = hit;
               count_in = count_ff - 1'b1;
               if (hit.due_time < clock_ff) begin
                  status = ST_BACKWARDS;
               end else begin
                  clock_in = hit.due_time;
               end
            end
         end
         OP_CANCEL, OP_LOOKUP: begin
            if (!found) begin
               status = ST_NOT_FOUND;
            end else begin
               res_slot = hit;
               if (op_ff == OP_CANCEL) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         OP_RESET: begin
            clock_in = start_ff;
         end
         default: begin
         end
      endcase
      rsp_data_in = {{(RSP_W - 145){1'b0}}, OCC_W'(count_in), clock_in, res_slot.handler,
                     res_slot.due_time, res_slot.uid, status};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         clock_ff     <= '0;
         next_id_ff   <= ID_W'(1);
         start_ff     <= '0;
      end else begin
         if (csr_valid) begin
            start_ff <= csr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && op_valid) begin
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               if (apply_fire) begin
                  state_ff <= (req_fire && op_valid) ? S_CMP : S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (apply_fire) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= count_in;
            clock_ff     <= clock_in;
            next_id_ff   <= next_id_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         op_ff      <= req_tdata[2:0];
         delay_ff   <= req_tdata[34:3];
         handler_ff <= req_tdata[42:35];
         uid_ff     <= req_tdata[73:43];
      end
      if (state_ff == S_CMP) begin
         due_ff <= due_in;
      end
      if (apply_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
